### sv/assert_macros.svh
// Assertion helpers for the RTL; ulcl_back.sv includes them.
// Both forms expect i_clk in the scope where they are used; ULCL_ASSERT also needs i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset
`define ULCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Checked on every rising clock edge, reset included
`define ULCL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ULCL_ASSERT(lbl, prop, msg)
`define ULCL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/ulcl_pkg.sv
package ulcl_pkg;

    // Item kinds passed from the front end to the back end
    localparam logic [1:0] K_STORE = 2'd0;
    localparam logic [1:0] K_ERASE = 2'd1;
    localparam logic [1:0] K_END   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] ch;
    } t_item;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Characters (all below 0x80)
    localparam logic [6:0] C_EOT    = 7'h04;
    localparam logic [6:0] C_BS     = 7'h08;
    localparam logic [6:0] C_LF     = 7'h0A;
    localparam logic [6:0] C_CR     = 7'h0D;
    localparam logic [6:0] C_SPACE  = 7'h20;
    localparam logic [6:0] C_TILDE  = 7'h7E;
    localparam logic [6:0] C_DEL    = 7'h7F;
    localparam logic [6:0] C_PROMPT = 7'h3E;
    localparam logic [6:0] C_L      = 7'h6C;
    localparam logic [6:0] C_E      = 7'h65;
    localparam logic [6:0] C_D      = 7'h64;
    localparam logic [6:0] C_PLUS   = 7'h2B;
    localparam logic [6:0] C_MINUS  = 7'h2D;
    localparam logic [6:0] C_ZERO   = 7'h30;
    localparam logic [6:0] C_THREE  = 7'h33;

    // Parse result codes
    localparam logic [2:0] E_OK     = 3'd0;
    localparam logic [2:0] E_SHORT  = 3'd1;
    localparam logic [2:0] E_PREFIX = 3'd2;
    localparam logic [2:0] E_OP     = 3'd3;
    localparam logic [2:0] E_LED    = 3'd4;
    localparam logic [2:0] E_LONG   = 3'd5;
    localparam logic [2:0] E_EMPTY  = 3'd6;

    // Byte of a three-byte reply: erase sequence or end-of-line prompt
    function automatic logic [7:0] seq_byte(input logic is_end, input logic [1:0] step);
        logic [6:0] c;
        case (step)
            2'd0:    c = is_end ? C_CR : C_BS;
            2'd1:    c = is_end ? C_LF : C_SPACE;
            default: c = is_end ? C_PROMPT : C_BS;
        endcase
        return {1'b0, c};
    endfunction

endpackage

### sv/ulcl_front.sv
module ulcl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    output logic             o_push,
    input  logic             i_q_ready,
    output ulcl_pkg::t_item  o_item
);

    logic            r_valid;
    ulcl_pkg::t_item r_item;
    logic            w_keep;
    ulcl_pkg::t_item w_item;

    // Sort the byte: line end, erase, printable, or dropped here
    always_comb begin
        w_keep      = 1'b1;
        w_item.ch   = i_byte[6:0];
        w_item.kind = ulcl_pkg::K_STORE;
        if (i_byte == {1'b0, ulcl_pkg::C_CR} || i_byte == {1'b0, ulcl_pkg::C_EOT}) begin
            w_item.kind = ulcl_pkg::K_END;
        end else if (i_byte == {1'b0, ulcl_pkg::C_BS} ||
                     i_byte == {1'b0, ulcl_pkg::C_DEL}) begin
            w_item.kind = ulcl_pkg::K_ERASE;
        end else if (i_byte < {1'b0, ulcl_pkg::C_SPACE} ||
                     i_byte > {1'b0, ulcl_pkg::C_TILDE}) begin
            w_keep = 1'b0;
        end
    end

    // One holding stage in front of the queue
    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= w_item;
        end
    end

endmodule

### sv/ulcl_queue.sv
module ulcl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  ulcl_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_pop,
    output ulcl_pkg::t_item  o_item
);

    localparam int AW = ulcl_pkg::QAW;

    ulcl_pkg::t_item                r_q [ulcl_pkg::QDEPTH];
    logic [ulcl_pkg::QAW-1:0]       r_wp;
    logic [ulcl_pkg::QAW-1:0]       r_rp;
    logic [ulcl_pkg::QAW:0]         r_cnt;
    logic                           w_wr;
    logic                           w_rd;

    assign o_ready = (r_cnt != (ulcl_pkg::QAW+1)'(ulcl_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + AW'(1);
            if (w_rd) r_rp <= r_rp + AW'(1);
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

### sv/ulcl_back.sv
`include "assert_macros.svh"
module ulcl_back #(
    parameter int LINE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  ulcl_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_tx,
    output logic             o_last,
    output logic             o_done,
    output logic [2:0]       o_err,
    output logic [3:0]       o_leds
);

    localparam int AW = $clog2(LINE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PARSE = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]     r_state;
    logic [AW-1:0]  r_fill;
    logic [AW-1:0]  r_idx;
    logic [3:0]     r_leds;
    logic           r_ov;
    logic [7:0]     r_tx;
    logic           r_last;
    logic           r_done;
    logic [2:0]     r_err;
    logic [1:0]     r_step;
    logic           r_seq_end;
    logic           r_rd_v;
    logic [6:0]     r_rd_data;
    logic [2:0]     r_len;
    logic [6:0]     r_cmd [5];
    logic [6:0]     r_mem [LINE_DEPTH];

    logic           w_room;
    logic           w_we;
    logic [2:0]     w_err;
    logic [3:0]     w_bit;
    logic [3:0]     w_leds;

    assign w_room  = (r_fill < AW'(LINE_DEPTH - 1));
    assign o_pop   = (r_state == S_IDLE) && !r_ov && i_valid;
    assign w_we    = o_pop && (i_item.kind == ulcl_pkg::K_STORE) && w_room;

    assign o_valid = r_ov;
    assign o_tx    = r_tx;
    assign o_last  = r_last;
    assign o_done  = r_done;
    assign o_err   = r_err;
    assign o_leds  = r_leds;

    // Line store: one write port, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_fill] <= i_item.ch;
        end
        r_rd_data <= r_mem[r_idx];
    end

    // Check of the collected command
    always_comb begin
        w_bit  = 4'b0001 << r_cmd[4][1:0];
        w_leds = r_leds;
        if (r_len == 3'd0) begin
            w_err = ulcl_pkg::E_EMPTY;
        end else if (r_len < 3'd5) begin
            w_err = ulcl_pkg::E_SHORT;
        end else if (r_len > 3'd5) begin
            w_err = ulcl_pkg::E_LONG;
        end else if (r_cmd[0] != ulcl_pkg::C_L || r_cmd[1] != ulcl_pkg::C_E ||
                     r_cmd[2] != ulcl_pkg::C_D) begin
            w_err = ulcl_pkg::E_PREFIX;
        end else if (r_cmd[3] != ulcl_pkg::C_PLUS && r_cmd[3] != ulcl_pkg::C_MINUS) begin
            w_err = ulcl_pkg::E_OP;
        end else if (r_cmd[4] < ulcl_pkg::C_ZERO || r_cmd[4] > ulcl_pkg::C_THREE) begin
            w_err = ulcl_pkg::E_LED;
        end else begin
            w_err  = ulcl_pkg::E_OK;
            w_leds = (r_cmd[3] == ulcl_pkg::C_PLUS) ? (r_leds | w_bit) : (r_leds & ~w_bit);
        end
    end

    // Sequencer: edit, scan, parse, reply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_leds    <= '0;
            r_ov      <= 1'b0;
            r_rd_v    <= 1'b0;
            r_step    <= 2'd0;
            r_seq_end <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_item.kind)
                            ulcl_pkg::K_STORE: begin
                                if (w_room) begin
                                    r_fill <= r_fill + AW'(1);
                                    r_ov   <= 1'b1;
                                    r_tx   <= {1'b0, i_item.ch};
                                    r_last <= 1'b1;
                                    r_done <= 1'b0;
                                    r_err  <= ulcl_pkg::E_OK;
                                end
                            end
                            ulcl_pkg::K_ERASE: begin
                                if (r_fill != '0) begin
                                    r_fill    <= r_fill - AW'(1);
                                    r_ov      <= 1'b1;
                                    r_tx      <= ulcl_pkg::seq_byte(1'b0, 2'd0);
                                    r_last    <= 1'b0;
                                    r_done    <= 1'b0;
                                    r_err     <= ulcl_pkg::E_OK;
                                    r_step    <= 2'd0;
                                    r_seq_end <= 1'b0;
                                    r_state   <= S_EMIT;
                                end
                            end
                            ulcl_pkg::K_END: begin
                                r_idx   <= '0;
                                r_len   <= 3'd0;
                                r_rd_v  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end else if (r_ov && i_ready) begin
                        r_ov <= 1'b0;
                    end
                end
                S_SCAN: begin
                    // one address issued per cycle, its data consumed in the next cycle
                    if (r_idx < r_fill) begin
                        r_idx  <= r_idx + AW'(1);
                        r_rd_v <= 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_rd_v && r_rd_data != ulcl_pkg::C_SPACE) begin
                        if (r_len < 3'd5) r_cmd[r_len] <= r_rd_data;
                        if (r_len < 3'd6) r_len <= r_len + 3'd1;
                    end
                    if (r_idx == r_fill && !r_rd_v) begin
                        r_state <= S_PARSE;
                    end
                end
                S_PARSE: begin
                    r_leds    <= w_leds;
                    r_fill    <= '0;
                    r_ov      <= 1'b1;
                    r_tx      <= ulcl_pkg::seq_byte(1'b1, 2'd0);
                    r_last    <= 1'b0;
                    r_done    <= 1'b1;
                    r_err     <= w_err;
                    r_step    <= 2'd0;
                    r_seq_end <= 1'b1;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_ov && i_ready) begin
                        if (r_step == 2'd2) begin
                            r_ov    <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_step <= r_step + 2'd1;
                            r_tx   <= ulcl_pkg::seq_byte(r_seq_end, r_step + 2'd1);
                            r_last <= (r_step == 2'd1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ULCL_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!r_ov && r_fill == '0 && r_leds == 4'd0), "reset left state behind")
    `ULCL_ASSERT(a_parse_reply, (r_state == S_PARSE) |=> (r_fill == '0 && r_ov && r_done && r_tx == {1'b0, ulcl_pkg::C_CR}), "line end reply not started")
    `ULCL_ASSERT(a_scan_bound, (r_state == S_SCAN) |-> (r_idx <= r_fill && !r_ov), "scan ran past the line")
    `ULCL_ASSERT(a_stall_hold, (r_ov && !i_ready) |=> (r_ov && $stable(r_tx) && $stable(r_err) && $stable(r_last)), "result changed while stalled")
    `ULCL_ASSERT(a_last_drains, (r_ov && i_ready && r_last) |=> !r_ov, "final result not released")

endmodule

### sv/uart_led_command_line.sv
// Serial command-line editor driving four LED bits.
// An echo or first erase byte passes the front holding stage, queue and back end output register.
// Line end: the line store is scanned, the command parsed, then CR LF '>' is sent.
// The back end takes a new edit byte only once its single output register has been read out.
// Reset (synchronous, active low) empties the line and the queue and turns all LEDs off.
module uart_led_command_line #(
    parameter int LINE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [10:8] parse_status, [14:11] led_state
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] line_done
);

    logic            w_push;
    logic            w_q_ready;
    logic            w_q_valid;
    logic            w_pop;
    ulcl_pkg::t_item w_front_item;
    ulcl_pkg::t_item w_back_item;
    logic [7:0]      w_tx;
    logic [2:0]      w_err;
    logic [3:0]      w_leds;

    // Front end: accept and sort received bytes
    ulcl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .o_push    (w_push),
        .i_q_ready (w_q_ready),
        .o_item    (w_front_item)
    );

    // Short queue between the two halves
    ulcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_item  (w_front_item),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_back_item)
    );

    // Back end: line store, parser and replies
    ulcl_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_pop   (w_pop),
        .i_item  (w_back_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tx    (w_tx),
        .o_last  (m_axis_tlast),
        .o_done  (m_axis_tuser),
        .o_err   (w_err),
        .o_leds  (w_leds)
    );

    assign m_axis_tdata = {1'b0, w_leds, w_err, w_tx};

endmodule

### dv/tb_uart_led_command_line.sv
`timescale 1ns / 1ps
module tb_uart_led_command_line;

    localparam int LINE_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 190;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;

    typedef struct {
        logic [7:0] rx;
        bit         drain;      // wait for every due reply byte before offering this one, except in the long hold-off
    } t_rx_item;

    typedef struct {
        logic [7:0] tx;
        logic       last;
        logic       done;
        logic [2:0] err;
        logic [3:0] led;
    } t_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [7:0] tx_byte, [10:8] parse_status, [14:11] led_state
    logic        m_axis_tlast;
    logic        m_axis_tuser;          // [0] line_done

    uart_led_command_line #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Line editor model: its own copy of the line, fill level and LEDs
    logic [6:0] line_buf [LINE_DEPTH];
    int         fill_cnt = 0;
    logic [3:0] led_now  = '0;
    t_reply     reply_due [$];
    t_rx_item   rx_backlog [$];

    int n_sent = 0;
    int n_got  = 0;
    int n_err  = 0;
    int n_lines = 0;
    int code_seen [7];
    int n_queued = 0;
    bit pause_next = 1'b0;

    function automatic void push_reply(logic [7:0] tx, logic last, logic done, logic [2:0] err);
        t_reply r;
        r.tx   = tx;
        r.last = last;
        r.done = done;
        r.err  = err;
        r.led  = led_now;
        reply_due.push_back(r);
    endfunction

    // Spaces skipped; length first, then prefix, operator and digit
    function automatic logic [2:0] parse_line();
        logic [6:0] cmd [5];
        int         n;
        logic [3:0] led_mask;
        n = 0;
        foreach (cmd[k]) cmd[k] = '0;
        for (int k = 0; k < fill_cnt; k++) begin
            if (line_buf[k] != ulcl_pkg::C_SPACE) begin
                if (n < 5) cmd[n] = line_buf[k];
                if (n < 6) n++;
            end
        end
        if (n == 0) return ulcl_pkg::E_EMPTY;
        if (n < 5) return ulcl_pkg::E_SHORT;
        if (n > 5) return ulcl_pkg::E_LONG;
        if (cmd[0] != ulcl_pkg::C_L || cmd[1] != ulcl_pkg::C_E || cmd[2] != ulcl_pkg::C_D)
            return ulcl_pkg::E_PREFIX;
        if (cmd[3] != ulcl_pkg::C_PLUS && cmd[3] != ulcl_pkg::C_MINUS) return ulcl_pkg::E_OP;
        if (cmd[4] < ulcl_pkg::C_ZERO || cmd[4] > ulcl_pkg::C_THREE) return ulcl_pkg::E_LED;
        led_mask = 4'b0001 << (cmd[4] - ulcl_pkg::C_ZERO);
        if (cmd[3] == ulcl_pkg::C_PLUS) led_now = led_now | led_mask;
        else led_now = led_now & ~led_mask;
        return ulcl_pkg::E_OK;
    endfunction

    function automatic void predict_reply(logic [7:0] rx);
        logic [2:0] err;
        if (rx == {1'b0, ulcl_pkg::C_CR} || rx == {1'b0, ulcl_pkg::C_EOT}) begin
            err = parse_line();
            fill_cnt = 0;
            n_lines++;
            code_seen[err]++;
            push_reply({1'b0, ulcl_pkg::C_CR}, 1'b0, 1'b1, err);
            push_reply({1'b0, ulcl_pkg::C_LF}, 1'b0, 1'b1, err);
            push_reply({1'b0, ulcl_pkg::C_PROMPT}, 1'b1, 1'b1, err);
        end else if (rx == {1'b0, ulcl_pkg::C_BS} || rx == {1'b0, ulcl_pkg::C_DEL}) begin
            // erase on an empty line gives nothing back
            if (fill_cnt > 0) begin
                fill_cnt--;
                push_reply({1'b0, ulcl_pkg::C_BS}, 1'b0, 1'b0, ulcl_pkg::E_OK);
                push_reply({1'b0, ulcl_pkg::C_SPACE}, 1'b0, 1'b0, ulcl_pkg::E_OK);
                push_reply({1'b0, ulcl_pkg::C_BS}, 1'b1, 1'b0, ulcl_pkg::E_OK);
            end
        end else if (rx >= {1'b0, ulcl_pkg::C_SPACE} && rx <= {1'b0, ulcl_pkg::C_TILDE}
                     && fill_cnt < LINE_DEPTH - 1) begin
            line_buf[fill_cnt] = rx[6:0];
            fill_cnt++;
            push_reply(rx, 1'b1, 1'b0, ulcl_pkg::E_OK);
        end
    endfunction

    function automatic int pick_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    // Stimulus helpers
    task automatic push_rx(logic [7:0] b);
        t_rx_item it;
        it.rx = b;
        it.drain = pause_next;
        pause_next = 1'b0;
        rx_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic push_text(string s);
        for (int k = 0; k < s.len(); k++) push_rx(s[k]);
    endtask

    function automatic logic [7:0] any_glyph();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [7:0] erase_byte();
        return $urandom_range(0, 1) ? {1'b0, ulcl_pkg::C_BS} : {1'b0, ulcl_pkg::C_DEL};
    endfunction

    // One line: well-formed commands in five of twelve cases, the rest aimed at each kind of parse failure
    task automatic gen_line();
        logic [7:0] body [$];
        int         kind;
        kind = $urandom_range(0, 11);
        if (kind <= 7) begin
            body.push_back({1'b0, ulcl_pkg::C_L});
            body.push_back({1'b0, ulcl_pkg::C_E});
            body.push_back({1'b0, ulcl_pkg::C_D});
            body.push_back($urandom_range(0, 1) ? {1'b0, ulcl_pkg::C_PLUS}
                                                : {1'b0, ulcl_pkg::C_MINUS});
            body.push_back(8'({1'b0, ulcl_pkg::C_ZERO}) + 8'($urandom_range(0, 3)));
            case (kind)
                5: body[$urandom_range(0, 2)] = any_glyph();
                6: body[3] = any_glyph();
                7: body[4] = any_glyph();
                default: ;
            endcase
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 4)) body.push_back(any_glyph());
        end else if (kind == 9) begin
            repeat ($urandom_range(6, 9)) body.push_back(any_glyph());
        end else if (kind == 11) begin
            repeat ($urandom_range(1, 3)) body.push_back(any_glyph());
        end
        foreach (body[k]) begin
            if ($urandom_range(0, 4) == 0) push_rx({1'b0, ulcl_pkg::C_SPACE});
            // typo corrected straight away
            if ($urandom_range(0, 9) == 0) begin
                push_rx(any_glyph());
                push_rx(erase_byte());
            end
            if ($urandom_range(0, 11) == 0) push_rx(8'($urandom_range(0, 255)));
            push_rx(body[k]);
        end
        if (kind == 10) repeat ($urandom_range(0, 3)) push_rx({1'b0, ulcl_pkg::C_SPACE});
        // erase one or two more bytes than the body holds, to reach past the start of the line
        if (kind == 11) repeat (body.size() + $urandom_range(1, 2)) push_rx(erase_byte());
        push_rx($urandom_range(0, 1) ? {1'b0, ulcl_pkg::C_CR} : {1'b0, ulcl_pkg::C_EOT});
    endtask

    // Driver: offers backlog bytes with random gaps, predicts on each transfer
    bit rx_offer = 1'b0;
    int rx_gap   = 0;
    bit rx_burst = 1'b0;
    bit hold_on  = 1'b0;    // receiver in its long hold-off: keep offering

    always @(posedge i_clk) begin
        t_rx_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (rx_offer && s_axis_tready) begin
                predict_reply(s_axis_tdata);
                rx_offer = 1'b0;
                n_sent++;
            end
            if (!rx_offer) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                end else if (rx_backlog.size() > 0
                             && !(rx_backlog[0].drain && reply_due.size() > 0 && !hold_on)) begin
                    it = rx_backlog.pop_front();
                    s_axis_tdata <= it.rx;
                    rx_offer = 1'b1;
                    if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
                    rx_gap = pick_gap(rx_burst);
                end
            end
            s_axis_tvalid <= rx_offer;
        end
    end

    // Monitor: random stalls, one long hold-off, field-by-field compare
    bit rd_ready  = 1'b0;
    int rd_stall  = 0;
    bit rd_burst  = 1'b0;
    bit hold_done = 1'b0;

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            n_err++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && rd_ready) begin
                if (reply_due.size() == 0) begin
                    $display("%0t ns: unexpected reply, expected none, got tdata %04h",
                             $time, m_axis_tdata);
                    n_err++;
                end else begin
                    want = reply_due.pop_front();
                    check_field("tx_byte", want.tx, m_axis_tdata[7:0]);
                    check_field("parse_status", want.err, m_axis_tdata[10:8]);
                    check_field("led_state", want.led, m_axis_tdata[14:11]);
                    check_field("last", want.last, m_axis_tlast);
                    check_field("line_done", want.done, m_axis_tuser);
                end
                n_got++;
                if ($urandom_range(0, 19) == 0) rd_burst = !rd_burst;
                rd_stall = pick_gap(rd_burst);
                // long back-pressure so the input side fills and stalls
                if (!hold_done && n_got == 60) begin
                    rd_stall = HOLD_CYCLES;
                    hold_done = 1'b1;
                    hold_on = 1'b1;
                end
            end
            if (rd_stall > 0) begin
                rd_stall--;
                rd_ready = 1'b0;
            end else begin
                rd_ready = 1'b1;
                hold_on = 1'b0;
            end
            m_axis_tready <= rd_ready;
        end
    end

    // Watchdog on cycles without any transfer
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        bit full_done;
        full_done = 1'b0;
        foreach (code_seen[k]) code_seen[k] = 0;

        // Directed: ignored bytes, erase on empty, empty line
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx({1'b0, ulcl_pkg::C_BS});
        push_rx({1'b0, ulcl_pkg::C_DEL});
        push_rx({1'b0, ulcl_pkg::C_CR});
        // set LED 3, tilde echoed then erased, EOT ends the line
        push_text("led+3");
        push_rx({1'b0, ulcl_pkg::C_TILDE});
        push_rx({1'b0, ulcl_pkg::C_DEL});
        push_rx({1'b0, ulcl_pkg::C_EOT});
        // spaces only, short line, spaced-out clear
        push_rx({1'b0, ulcl_pkg::C_SPACE});
        push_rx({1'b0, ulcl_pkg::C_CR});
        push_text("ab");
        push_rx({1'b0, ulcl_pkg::C_CR});
        push_text("l ed-3");
        push_rx({1'b0, ulcl_pkg::C_CR});
        pause_next = 1'b1;

        // Random lines, with stray bytes and the odd pause for the replies
        n_queued = 0;
        while (n_queued < RANDOM_ITEMS) begin
            if ($urandom_range(0, 11) == 0) pause_next = 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) push_rx(8'($urandom_range(0, 255)));
            // overfill the line once: drops, erase, refill the last slot
            if (!full_done && n_queued >= 100) begin
                full_done = 1'b1;
                repeat (LINE_DEPTH + 5) push_rx(8'($urandom_range(8'h20, 8'h7E)));
                push_rx(erase_byte());
                push_rx(any_glyph());
                push_rx(any_glyph());
                push_rx({1'b0, ulcl_pkg::C_CR});
            end
            gen_line();
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_backlog.size() > 0 || rx_offer || reply_due.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d bytes, checked %0d reply bytes over %0d finished lines.",
                 n_sent, n_got, n_lines);
        $display("Parse codes ok/short/prefix/op/digit/long/empty: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 code_seen[ulcl_pkg::E_OK], code_seen[ulcl_pkg::E_SHORT],
                 code_seen[ulcl_pkg::E_PREFIX], code_seen[ulcl_pkg::E_OP],
                 code_seen[ulcl_pkg::E_LED], code_seen[ulcl_pkg::E_LONG],
                 code_seen[ulcl_pkg::E_EMPTY]);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/ulcl_pkg.sv
sv/ulcl_front.sv
sv/ulcl_queue.sv
sv/ulcl_back.sv
sv/uart_led_command_line.sv
dv/tb_uart_led_command_line.sv
